// ===== rtl/cdo_pkg.sv =====
// Shared types, constants and helper functions of the calendar date offset block.
package cdo_pkg;

   localparam int DAY_W = 21;

   localparam logic [20:0] DAYS_PER_ERA   = 21'd146097;
   localparam logic [17:0] DAYS_PER_CENT  = 18'd36524;
   localparam logic [17:0] LAST_ERA_DAY   = 18'd146096;
   localparam logic [13:0] YEAR_BIAS      = 14'd400;
   localparam logic [13:0] YEAR_LOW       = 14'd1600;
   localparam logic [13:0] YEAR_HIGH      = 14'd4095;
   localparam logic [3:0]  MONTH_NONE     = 4'd0;
   localparam logic [3:0]  MONTH_LAST     = 4'd12;
   localparam logic [3:0]  MONTH_FEB      = 4'd2;
   localparam logic [3:0]  ERA_COUNT      = 4'd11;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   typedef struct packed {
      date_type    date;
      logic [2:0]  wd0;
   } side_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [2:0]  wd;
   } result_type;

   // Day of the year at which each month starts, counted from the first of March.
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] s;
      case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

   function automatic logic [20:0] era_base(input logic [3:0] era);
      return 21'(era) * DAYS_PER_ERA;
   endfunction

   // Residue modulo seven by folding three-bit groups, since eight is one modulo seven.
   function automatic logic [2:0] mod7(input logic [20:0] n);
      logic [5:0] s1;
      logic [3:0] s2;
      logic [3:0] s3;
      s1 = 6'(n[2:0]) + 6'(n[5:3]) + 6'(n[8:6]) + 6'(n[11:9]) + 6'(n[14:12])
         + 6'(n[17:15]) + 6'(n[20:18]);
      s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
      s3 = 4'(s2[2:0]) + 4'(s2[3]);
      return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
   endfunction

   // Day number zero falls on a Wednesday, so the weekday is the residue plus three.
   function automatic logic [2:0] weekday_of(input logic [20:0] n);
      logic [3:0] r;
      r = 4'(mod7(n)) + 4'd3;
      return (r >= 4'd7) ? 3'(r - 4'd7) : r[2:0];
   endfunction

endpackage

// ===== rtl/cdo_dnum.sv =====
// Three-stage pipeline that turns a calendar date into a day number.
module cdo_dnum (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  cdo_pkg::date_type           in_date,
   input  logic signed [16:0]          in_offset,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [cdo_pkg::DAY_W-1:0]   out_day_num,
   output cdo_pkg::date_type           out_date,
   output logic signed [16:0]          out_offset
);
   import cdo_pkg::*;

   logic [2:0]         vld_ff;
   logic [2:0]         vld_in;
   logic [2:0]         rdy;

   date_type           date_ff [0:2];
   logic signed [16:0] off_ff  [0:2];

   logic [13:0]        ys;
   logic [13:0]        yadj;
   logic [3:0]         mn;
   logic [3:0]         mp;
   logic [12:0]        yy_in;
   logic [12:0]        yy_ff;
   logic signed [9:0]  doym_in;
   logic signed [9:0]  doym_ff [0:1];

   logic [21:0]        prod100;
   logic [19:0]        prod400;
   logic [20:0]        p365_in;
   logic [20:0]        p365_ff;
   logic [5:0]         q100_in;
   logic [5:0]         q100_ff;
   logic [3:0]         q400_in;
   logic [3:0]         q400_ff;
   logic [10:0]        q4_ff;

   logic [20:0]        n0_in;
   logic [20:0]        n0_ff;

   always_comb begin
      rdy[2] = !vld_ff[2] || out_ready;
      rdy[1] = !vld_ff[1] || rdy[2];
      rdy[0] = !vld_ff[0] || rdy[1];
      vld_in[0] = rdy[0] ? in_valid  : vld_ff[0];
      vld_in[1] = rdy[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = rdy[2] ? vld_ff[1] : vld_ff[2];
   end

   always_comb begin
      ys = {2'b00, in_date.year};
      mn = in_date.month;
      if (in_date.month == MONTH_NONE) begin
         ys = {2'b00, in_date.year} - 14'd1;
         mn = MONTH_LAST;
      end else if (in_date.month inside {[4'd13:4'd15]}) begin
         ys = {2'b00, in_date.year} + 14'd1;
         mn = in_date.month - MONTH_LAST;
      end
      if (mn > MONTH_FEB) begin
         mp   = mn - 4'd3;
         yadj = ys;
      end else begin
         mp   = mn + 4'd9;
         yadj = ys - 14'd1;
      end
      yy_in   = 13'(yadj + YEAR_BIAS);
      doym_in = $signed({1'b0, month_start(mp)}) + $signed({5'b00000, in_date.day})
              - 10'sd1;
   end

   always_comb begin
      p365_in = 21'(yy_ff) * 21'd365;
      prod100 = 22'(yy_ff[12:2]) * 22'd1311;
      prod400 = 20'(yy_ff[12:4]) * 20'd1311;
      q100_in = prod100[20:15];
      q400_in = prod400[18:15];
   end

   assign n0_in = p365_ff + 21'(q4_ff) - 21'(q100_ff) + 21'(q400_ff) + 21'(doym_ff[1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         yy_ff      <= yy_in;
         doym_ff[0] <= doym_in;
         date_ff[0] <= in_date;
         off_ff[0]  <= in_offset;
      end
      if (rdy[1]) begin
         p365_ff    <= p365_in;
         q4_ff      <= yy_ff[12:2];
         q100_ff    <= q100_in;
         q400_ff    <= q400_in;
         doym_ff[1] <= doym_ff[0];
         date_ff[1] <= date_ff[0];
         off_ff[1]  <= off_ff[0];
      end
      if (rdy[2]) begin
         n0_ff      <= n0_in;
         date_ff[2] <= date_ff[1];
         off_ff[2]  <= off_ff[1];
      end
   end

   assign in_ready    = rdy[0];
   assign out_valid   = vld_ff[2];
   assign out_day_num = n0_ff;
   assign out_date    = date_ff[2];
   assign out_offset  = off_ff[2];

endmodule

// ===== rtl/cdo_dsplit.sv =====
// Seven-stage pipeline that turns a day number back into year, month, day and weekday.
module cdo_dsplit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [cdo_pkg::DAY_W-1:0]   in_day_num,
   input  cdo_pkg::side_type           in_side,
   output logic                        out_valid,
   input  logic                        out_ready,
   output cdo_pkg::result_type         out_res,
   output cdo_pkg::side_type           out_side
);
   import cdo_pkg::*;

   logic [6:0]   vld_ff;
   logic [6:0]   vld_in;
   logic [6:0]   rdy;

   side_type     side_ff [0:6];
   logic [2:0]   wd_ff   [0:5];
   logic [17:0]  doe_ff  [0:4];
   logic [3:0]   era_ff  [0:4];
   logic [8:0]   yoe_ff  [3:4];

   logic [3:0]   era_in;
   logic [17:0]  doe_in;

   logic [32:0]  prod_a;
   logic [6:0]   a_in;
   logic [6:0]   a_ff;
   logic [2:0]   b_in;
   logic [2:0]   b_ff;
   logic         c_ff;

   logic [17:0]  t_in;
   logic [17:0]  t_ff;

   logic [36:0]  prod_t;

   logic [16:0]  prod_q;
   logic [17:0]  sub_in;
   logic [17:0]  sub_ff;

   logic [8:0]   doy_in;
   logic [8:0]   doy_ff;
   logic [12:0]  yr_in;
   logic [12:0]  yr_ff;

   logic [3:0]   mp;
   result_type   res_in;
   result_type   res_ff;

   always_comb begin
      rdy[6] = !vld_ff[6] || out_ready;
      for (int s = 5; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s + 1];
      end
      vld_in[0] = rdy[0] ? in_valid : vld_ff[0];
      for (int s = 1; s < 7; s++) begin
         vld_in[s] = rdy[s] ? vld_ff[s - 1] : vld_ff[s];
      end
   end

   always_comb begin
      era_in = '0;
      for (int k = 1; k <= int'(ERA_COUNT); k++) begin
         if (in_day_num >= era_base(4'(k))) begin
            era_in = 4'(k);
         end
      end
      doe_in = 18'(in_day_num - era_base(era_in));
   end

   always_comb begin
      prod_a = 33'(doe_ff[0][17:2]) * 33'd91930;
      a_in   = prod_a[31:25];
      b_in   = '0;
      for (int k = 1; k <= 4; k++) begin
         if (doe_ff[0] >= 18'(k) * DAYS_PER_CENT) begin
            b_in = 3'(k);
         end
      end
   end

   assign t_in   = doe_ff[1] - 18'(a_ff) + 18'(b_ff) - 18'(c_ff);
   assign prod_t = 37'(t_ff) * 37'd367720;

   always_comb begin
      prod_q = 17'(yoe_ff[3][8:2]) * 17'd1311;
      sub_in = 18'(yoe_ff[3]) * 18'd365 + 18'(yoe_ff[3][8:2]) - 18'(prod_q[16:15]);
   end

   assign doy_in = 9'(doe_ff[4] - sub_ff);
   assign yr_in  = 13'(era_ff[4]) * 13'd400 + 13'(yoe_ff[4]);

   always_comb begin
      mp = '0;
      for (int k = 1; k < 12; k++) begin
         if (doy_ff >= month_start(4'(k))) begin
            mp = 4'(k);
         end
      end
      res_in.day   = 5'(doy_ff - month_start(mp) + 9'd1);
      res_in.month = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
      res_in.year  = 14'(yr_ff) + 14'(mp >= 4'd10) - YEAR_BIAS;
      res_in.wd    = wd_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         era_ff[0]  <= era_in;
         doe_ff[0]  <= doe_in;
         wd_ff[0]   <= weekday_of(in_day_num);
         side_ff[0] <= in_side;
      end
      for (int s = 1; s < 7; s++) begin
         if (rdy[s]) begin
            side_ff[s] <= side_ff[s - 1];
         end
      end
      for (int s = 1; s < 6; s++) begin
         if (rdy[s]) begin
            wd_ff[s] <= wd_ff[s - 1];
         end
      end
      for (int s = 1; s < 5; s++) begin
         if (rdy[s]) begin
            doe_ff[s] <= doe_ff[s - 1];
            era_ff[s] <= era_ff[s - 1];
         end
      end
      if (rdy[1]) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= (doe_ff[0] == LAST_ERA_DAY);
      end
      if (rdy[2]) begin
         t_ff <= t_in;
      end
      if (rdy[3]) begin
         yoe_ff[3] <= prod_t[35:27];
      end
      if (rdy[4]) begin
         yoe_ff[4] <= yoe_ff[3];
         sub_ff    <= sub_in;
      end
      if (rdy[5]) begin
         doy_ff <= doy_in;
         yr_ff  <= yr_in;
      end
      if (rdy[6]) begin
         res_ff <= res_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[6];
   assign out_res   = res_ff;
   assign out_side  = side_ff[6];

endmodule

// ===== rtl/calendar_date_offset.sv =====
// Top level of the calendar date offset block: day-number pipelines, offset add and result register.
//
// Usage: each beat on the req channel carries a proleptic Gregorian date and a signed day
// offset. The date is first normalised, so that day zero, month zero and months above twelve
// roll into the neighbouring month or year, then the offset is added and one beat leaves on
// the rsp channel with the resulting date and its weekday, Sunday being zero.
// When the resulting year falls outside 1600 to 4095, rsp_tuser is set, the input date is
// returned unchanged and the weekday is that of the normalised input date.
// From an accepted req beat to its rsp beat, three stages form the day number, one adds the
// offset, seven split the sum back into a date through constant reciprocal multiplies, and
// one registers the result. Throughput is one beat per cycle while rsp_tready stays high.
// Every stage carries its own valid bit and loads whenever it is empty or the stage after
// it moves, so a stall on rsp_tready fills bubbles first and only then lowers req_tready;
// nothing is lost or repeated.
// Reset clears all valid bits, which empties the pipeline; the data registers are not reset.
module calendar_date_offset (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // year_in[11:0], month_in[15:12], day_in[20:16],
                                   // day_offset[37:21], zero[39:38]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // year_out[11:0], month_out[15:12], day_out[20:16],
                                   // week_day[23:21]
   output logic [0:0]  rsp_tuser   // out_of_range[0]
);
   import cdo_pkg::*;

   date_type           req_date;
   logic signed [16:0] req_offset;

   logic               dn_valid;
   logic               dn_ready;
   logic [DAY_W-1:0]   dn_num;
   date_type           dn_date;
   logic signed [16:0] dn_offset;

   logic               add_vld_ff;
   logic               add_rdy;
   logic [DAY_W-1:0]   n1_in;
   logic [DAY_W-1:0]   n1_ff;
   side_type           side_in;
   side_type           side_ff;

   logic               ds_in_ready;
   logic               ds_valid;
   logic               ds_ready;
   result_type         ds_res;
   side_type           ds_side;

   logic               oor;
   logic               out_vld_ff;
   logic [11:0]        year_in;
   logic [11:0]        year_ff;
   logic [3:0]         month_in;
   logic [3:0]         month_ff;
   logic [4:0]         day_in;
   logic [4:0]         day_ff;
   logic [2:0]         wd_in;
   logic [2:0]         wd_ff;
   logic               oor_ff;

   assign req_date.year  = req_tdata[11:0];
   assign req_date.month = req_tdata[15:12];
   assign req_date.day   = req_tdata[20:16];
   assign req_offset     = $signed(req_tdata[37:21]);

   cdo_dnum u_dnum (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_date     (req_date),
      .in_offset   (req_offset),
      .out_valid   (dn_valid),
      .out_ready   (dn_ready),
      .out_day_num (dn_num),
      .out_date    (dn_date),
      .out_offset  (dn_offset)
   );

   assign add_rdy      = !add_vld_ff || ds_in_ready;
   assign dn_ready     = add_rdy;
   assign n1_in        = dn_num + 21'(dn_offset);
   assign side_in.date = dn_date;
   assign side_in.wd0  = weekday_of(dn_num);

   always_ff @(posedge clock) begin
      if (reset) begin
         add_vld_ff <= 1'b0;
      end else if (add_rdy) begin
         add_vld_ff <= dn_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (add_rdy) begin
         n1_ff   <= n1_in;
         side_ff <= side_in;
      end
   end

   cdo_dsplit u_dsplit (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (add_vld_ff),
      .in_ready   (ds_in_ready),
      .in_day_num (n1_ff),
      .in_side    (side_ff),
      .out_valid  (ds_valid),
      .out_ready  (ds_ready),
      .out_res    (ds_res),
      .out_side   (ds_side)
   );

   assign ds_ready = !out_vld_ff || rsp_tready;

   always_comb begin
      oor = ($signed(ds_res.year) < $signed(YEAR_LOW))
         || ($signed(ds_res.year) > $signed(YEAR_HIGH));
      if (oor) begin
         year_in  = ds_side.date.year;
         month_in = ds_side.date.month;
         day_in   = ds_side.date.day;
         wd_in    = ds_side.wd0;
      end else begin
         year_in  = ds_res.year[11:0];
         month_in = ds_res.month;
         day_in   = ds_res.day;
         wd_in    = ds_res.wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (ds_ready) begin
         out_vld_ff <= ds_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ds_ready) begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         wd_ff    <= wd_in;
         oor_ff   <= oor;
      end
   end

   assign rsp_tvalid   = out_vld_ff;
   assign rsp_tdata    = {wd_ff, day_ff, month_ff, year_ff};
   assign rsp_tuser[0] = oor_ff;

`ifndef SYNTHESIS
   a_reset_empties : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result beat present straight after reset.");

   a_month_legal : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[15:12] >= 4'd1 && rsp_tdata[15:12] <= 4'd12))
      else $error("Computed month outside one to twelve.");

   a_day_legal : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[20:16] >= 5'd1))
      else $error("Computed day of month is zero.");

   a_weekday_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:21] <= 3'd6))
      else $error("Weekday code above Saturday.");
`endif

endmodule
